### rtl/cmac_pkg.sv
package cmac_pkg;

	typedef struct packed {
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [4:0]  valid_bytes;
		logic        last_block;
		logic [63:0] expected_hi;
		logic [63:0] expected_lo;
	} in_item_t;

	typedef struct packed {
		logic [63:0] tag_hi;
		logic [63:0] tag_lo;
		logic        mismatch;
	} out_item_t;

	// Classified block handed from the front part to the AES engine.
	typedef struct packed {
		logic [127:0] block;
		logic         last;
		logic [127:0] expected;
	} job_t;

	localparam logic [0:0] REG_KEY_HI = 1'b0;
	localparam logic [0:0] REG_KEY_LO = 1'b1;
	localparam logic [7:0] RB_CONST   = 8'h87;
	localparam logic [7:0] PAD_BYTE   = 8'h80;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_KEY,
		ENG_SUB,
		ENG_RUN
	} eng_state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit block sits at bits 127-8i downto 120-8i.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i + 4 * c] = sbox(s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]);
		for (int c = 0; c < 4; c++) begin
			a0 = t[4 * c];
			a1 = t[4 * c + 1];
			a2 = t[4 * c + 2];
			a3 = t[4 * c + 3];
			if (final_rnd) begin
				r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
			end else begin
				r[127 - 32 * c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				r[127 - 32 * c - 8 -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				r[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				r[127 - 32 * c - 24 -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		return r;
	endfunction

	function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [127:0] dbl(input logic [127:0] a);
		return {a[126:0], 1'b0} ^ {120'd0, (a[127] ? RB_CONST : 8'h00)};
	endfunction

endpackage

### rtl/cmac_front.sv
module cmac_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cmac_pkg::in_item_t in_item,
	output logic               job_valid,
	input  logic               job_take,
	output cmac_pkg::job_t     job,
	input  logic [127:0]       k1,
	input  logic [127:0]       k2
);
	import cmac_pkg::*;

	// Two-entry queue of input items, classified at its output. The subkey XOR is applied when the
	// job is launched, so each block uses the subkeys current at that time.
	in_item_t   q_mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	in_item_t   h;
	logic [127:0] blk, padded;
	logic [4:0]   vb;

	assign in_stall  = cnt_q == 2'd2;
	assign push      = in_valid && !in_stall;
	assign job_valid = cnt_q != 2'd0;
	assign pop       = job_valid && job_take;

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_comb begin
		h   = q_mem[rd_q];
		blk = {h.data_hi, h.data_lo};
		vb  = h.valid_bytes;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < vb)
				padded[127 - 8 * i -: 8] = blk[127 - 8 * i -: 8];
			else if (5'(i) == vb)
				padded[127 - 8 * i -: 8] = PAD_BYTE;
			else
				padded[127 - 8 * i -: 8] = 8'h00;
		end
		job.last     = h.last_block;
		job.expected = {h.expected_hi, h.expected_lo};
		if (!h.last_block)
			job.block = blk;
		else if (vb >= 5'd16)
			job.block = blk ^ k1;
		else
			job.block = padded ^ k2;
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_q == 2'd2 && push)) else $error("queue overflow");

	property p_no_under;
		@(posedge clk) disable iff (!arst_n) cnt_q == 2'd0 |-> !pop;
	endproperty
	a_no_under: assert property (p_no_under) else $error("queue underflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("bad count");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
endmodule

### rtl/cmac_engine.sv
module cmac_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [63:0]       cfg_data,
	input  logic              job_valid,
	output logic              job_take,
	input  cmac_pkg::job_t    job,
	output logic [127:0]      k1,
	output logic [127:0]      k2,
	output logic              out_valid,
	input  logic              out_stall,
	output cmac_pkg::out_item_t out_item
);
	import cmac_pkg::*;

	eng_state_t   st_q, st_nx;
	logic [127:0] key_q, rk_q, state_q, chain_q, k1_q, expected_q;
	logic [3:0]   rnd_q;
	logic         last_q, kdirty_q, ovalid_q;
	out_item_t    obuf_q;
	logic [127:0] rnd_out, rk_nx;
	logic         start, done, obuf_free, tag_fire;

	assign k1 = k1_q;
	assign k2 = dbl(k1_q);
	assign out_valid = ovalid_q;
	assign out_item  = obuf_q;
	assign obuf_free = !ovalid_q || !out_stall;
	assign rk_nx     = next_rkey(rk_q, rcon(rnd_q));
	assign rnd_out   = aes_round(state_q, rnd_q == 4'd10) ^ rk_nx;
	assign done      = (st_q == ENG_RUN || st_q == ENG_SUB) && rnd_q == 4'd10;
	assign tag_fire  = st_q == ENG_RUN && rnd_q == 4'd10 && last_q && obuf_free;

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ENG_IDLE: if (kdirty_q) begin
					if (!cfg_we) st_nx = ENG_SUB;
				end else if (job_valid) st_nx = ENG_RUN;
			ENG_KEY:  st_nx = ENG_SUB;
			ENG_SUB:  if (rnd_q == 4'd10) st_nx = ENG_IDLE;
			ENG_RUN:  if (rnd_q == 4'd10 && (!last_q || obuf_free)) st_nx = ENG_IDLE;
			default:  st_nx = ENG_IDLE;
		endcase
	end

	always_comb begin
		job_take = st_q == ENG_IDLE && !kdirty_q && job_valid;
		start    = job_take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ENG_IDLE;
			key_q      <= '0;
			kdirty_q   <= 1'b1;
			chain_q    <= '0;
			ovalid_q   <= 1'b0;
			rnd_q      <= 4'd0;
			rk_q       <= '0;
			state_q    <= '0;
			k1_q       <= '0;
			last_q     <= 1'b0;
			expected_q <= '0;
			obuf_q     <= '0;
		end else begin
			st_q <= st_nx;
			if (tag_fire)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_KEY_HI)
					key_q[127:64] <= cfg_data;
				else
					key_q[63:0] <= cfg_data;
				kdirty_q <= 1'b1;
			end
			if (st_q == ENG_IDLE && kdirty_q && !cfg_we) begin
				kdirty_q <= 1'b0;
				rk_q     <= key_q;
				state_q  <= key_q;
				rnd_q    <= 4'd1;
			end else if (start) begin
				rk_q       <= key_q;
				state_q    <= job.block ^ chain_q ^ key_q;
				last_q     <= job.last;
				expected_q <= job.expected;
				rnd_q      <= 4'd1;
			end else if (st_q == ENG_SUB || st_q == ENG_RUN) begin
				if (rnd_q != 4'd10) begin
					state_q <= rnd_out;
					rk_q    <= rk_nx;
					rnd_q   <= rnd_q + 4'd1;
				end else if (st_q == ENG_SUB) begin
					k1_q <= dbl(rnd_out);
				end else if (!last_q) begin
					chain_q <= rnd_out;
				end else if (obuf_free) begin
					chain_q         <= '0;
					obuf_q.tag_hi   <= rnd_out[127:64];
					obuf_q.tag_lo   <= rnd_out[63:0];
					obuf_q.mismatch <= rnd_out != expected_q;
				end
			end
		end
	end

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> st_q == ENG_RUN && rnd_q == 4'd1) else $error("launch slip");
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ENG_RUN |-> rnd_q != 4'd0 && rnd_q <= 4'd10) else $error("round range");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(st_q) == ENG_RUN && $past(last_q)) else $error("spurious tag");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done && st_q == ENG_SUB |=> st_q == ENG_IDLE) else $error("subkey stuck");
endmodule

### rtl/aes128_cmac_generate_verify_core.sv
// AES-128 CMAC tag generator and checker (RFC 4493). Write the key through
// the configuration port (index 0 = key bytes 0..7, index 1 = bytes 8..15);
// after any write, the block derives the subkeys from AES(K,0) before it
// starts the next message block. Feed one 16-byte message block per item,
// first byte in the top bits of data_hi. Blocks are chained; the item with
// last_block set returns the tag and a mismatch flag against the expected
// tag, other items return nothing. A front queue of two items accepts and
// classifies blocks while the round engine works, so the input side keeps
// taking items until the queue is full while a tag waits at the output. The
// single AES round unit runs one round per cycle with round keys generated
// on the fly, and starts a new item only when it is through with the last.
module aes128_cmac_generate_verify_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  cmac_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output cmac_pkg::out_item_t out_item
);
	import cmac_pkg::*;

	logic         job_valid, job_take;
	job_t         job;
	logic [127:0] k1, k2;

	cmac_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.job_valid, .job_take, .job, .k1, .k2
	);

	cmac_engine u_engine (
		.clk, .arst_n, .cfg_we, .cfg_idx(cfg_idx[0]), .cfg_data,
		.job_valid, .job_take, .job, .k1, .k2,
		.out_valid, .out_stall, .out_item
	);
endmodule

### sim/cmac_tag_checker.sv
`timescale 1ns / 1ps

module cmac_tag_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  cmac_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_stall,
	input  cmac_pkg::out_item_t out_item,
	output int                  errors,
	output int                  pending,
	output int                  tags_seen,
	output int                  mismatches_seen,
	output logic [127:0]        last_tag
);

	logic [7:0]   sb_tab [256];
	logic [127:0] sched [11];
	logic [63:0]  key_hi_q, key_lo_q;
	logic [127:0] chain_q, k1_q, k2_q;
	cmac_pkg::out_item_t tag_fifo [$];

	initial begin
		sb_tab = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
	end

	function automatic logic [7:0] gf_mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] res;
		for (int i = 0; i < 16; i++)
			s[i] = pt[127 - 8 * i -: 8] ^ sched[0][127 - 8 * i -: 8];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[i + 4 * c] = sb_tab[s[i + 4 * ((c + i) % 4)]];
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				if (r < 10) begin
					s[4 * c]     = gf_mul2(a0) ^ gf_mul2(a1) ^ a1 ^ a2 ^ a3;
					s[4 * c + 1] = a0 ^ gf_mul2(a1) ^ gf_mul2(a2) ^ a2 ^ a3;
					s[4 * c + 2] = a0 ^ a1 ^ gf_mul2(a2) ^ gf_mul2(a3) ^ a3;
					s[4 * c + 3] = gf_mul2(a0) ^ a0 ^ a1 ^ a2 ^ gf_mul2(a3);
				end else begin
					s[4 * c]     = a0;
					s[4 * c + 1] = a1;
					s[4 * c + 2] = a2;
					s[4 * c + 3] = a3;
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] ^= sched[r][127 - 8 * i -: 8];
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] a);
		return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
	endfunction

	// Rebuilds the round key schedule and both subkeys from the current key.
	task automatic load_key();
		logic [31:0]  w [4];
		logic [31:0]  t;
		logic [7:0]   rc;
		logic [127:0] l;
		sched[0] = {key_hi_q, key_lo_q};
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			for (int j = 0; j < 4; j++)
				w[j] = sched[r - 1][127 - 32 * j -: 32];
			t = {sb_tab[w[3][23:16]] ^ rc, sb_tab[w[3][15:8]], sb_tab[w[3][7:0]],
				sb_tab[w[3][31:24]]};
			w[0] ^= t;
			w[1] ^= w[0];
			w[2] ^= w[1];
			w[3] ^= w[2];
			sched[r] = {w[0], w[1], w[2], w[3]};
			rc = gf_mul2(rc);
		end
		l = encrypt_block(128'h0);
		k1_q = gf_double(l);
		k2_q = gf_double(k1_q);
	endtask

	task automatic report_mismatch(input string what, input logic [127:0] got,
			input logic [127:0] want);
		$display("%0t: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// Predicts the effect of one accepted message block.
	task automatic absorb_block(input cmac_pkg::in_item_t it);
		logic [127:0] blk;
		logic [127:0] keep;
		cmac_pkg::out_item_t exp_tag;
		blk = {it.data_hi, it.data_lo};
		if (!it.last_block) begin
			chain_q = encrypt_block(blk ^ chain_q);
		end else begin
			if (it.valid_bytes >= 5'd16) begin
				blk ^= k1_q;
			end else begin
				keep = ~({128{1'b1}} >> (8 * it.valid_bytes));
				blk = (blk & keep) | (128'h80 << (120 - 8 * it.valid_bytes));
				blk ^= k2_q;
			end
			blk = encrypt_block(blk ^ chain_q);
			exp_tag.tag_hi = blk[127:64];
			exp_tag.tag_lo = blk[63:0];
			exp_tag.mismatch = (blk != {it.expected_hi, it.expected_lo});
			tag_fifo.push_back(exp_tag);
			last_tag = blk;
			chain_q = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q = '0;
			key_lo_q = '0;
			chain_q = '0;
			tag_fifo.delete();
			errors = 0;
			tags_seen = 0;
			mismatches_seen = 0;
			last_tag = '0;
			load_key();
		end else begin
			if (out_valid && !out_stall) begin
				tags_seen++;
				if (out_item.mismatch)
					mismatches_seen++;
				if (tag_fifo.size() == 0) begin
					report_mismatch("unexpected tag", {out_item.tag_hi, out_item.tag_lo}, '0);
				end else begin
					if (out_item.tag_hi != tag_fifo[0].tag_hi ||
							out_item.tag_lo != tag_fifo[0].tag_lo)
						report_mismatch("tag", {out_item.tag_hi, out_item.tag_lo},
							{tag_fifo[0].tag_hi, tag_fifo[0].tag_lo});
					if (out_item.mismatch != tag_fifo[0].mismatch)
						report_mismatch("mismatch flag", 128'(out_item.mismatch),
							128'(tag_fifo[0].mismatch));
					void'(tag_fifo.pop_front());
				end
			end
			if (in_valid && !in_stall)
				absorb_block(in_item);
			if (cfg_we) begin
				if (cfg_idx == cmac_pkg::REG_KEY_HI)
					key_hi_q = cfg_data;
				else
					key_lo_q = cfg_data;
				load_key();
			end
		end
		pending = tag_fifo.size();
	end

endmodule

### sim/tb_aes128_cmac_generate_verify_core.sv
`timescale 1ns / 1ps

// Top of the CMAC testbench. It resets the core, writes keys while the core is
// idle, and feeds messages of one to four blocks. The checker beside the core
// predicts every tag and flags every difference; this module only makes
// stimulus, shapes the handshakes and gives the verdict.
module tb_aes128_cmac_generate_verify_core;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_idx;
	logic [63:0]         cfg_data;
	logic                in_valid;
	logic                in_stall;
	cmac_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	cmac_pkg::out_item_t out_item;

	int           errors, pending, tags_seen, mismatches_seen;
	logic [127:0] last_tag;

	int   items_sent;
	int   keys_written;
	int   burst_left;
	int   idle_cycles;
	logic hold_go;

	aes128_cmac_generate_verify_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	cmac_tag_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.errors         (errors),
		.pending        (pending),
		.tags_seen      (tags_seen),
		.mismatches_seen(mismatches_seen),
		.last_tag       (last_tag)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver periodically picks a new random stall pattern. Once the
	// stimulus raises hold_go, it holds off for a long stretch so that the
	// front queue of the core fills and the input side backs up.
	initial begin
		int  mode;
		int  tick;
		int  hold_left;
		logic hold_done;
		mode = 0;
		tick = 0;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 1) == 0);
					end
					2: begin
						out_stall <= (tick % 3 == 0);
					end
					default: begin
						out_stall <= ($urandom_range(0, 7) != 0);
					end
				endcase
			end
		end
	end

	// The watchdog ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Writes one key register at a falling edge; the write happens at the
	// following rising edge.
	task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		keys_written++;
	endtask

	// Loads a full key and lets the subkey derivation run to completion.
	task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
		write_key(cmac_pkg::REG_KEY_HI, hi);
		write_key(cmac_pkg::REG_KEY_LO, lo);
		repeat (40) @(posedge clk);
	endtask

	// Offers one item and holds it until the core accepts it. Bursts end in a
	// random gap with valid low, or with none.
	task automatic send_block(input cmac_pkg::in_item_t it);
		int gap;
		@(negedge clk);
		in_item <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Lowers valid and waits until every predicted tag has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_last(input logic [127:0] data, input logic [4:0] nbytes,
			input logic [127:0] tag);
		cmac_pkg::in_item_t it;
		it.data_hi = data[127:64];
		it.data_lo = data[63:0];
		it.valid_bytes = nbytes;
		it.last_block = 1'b1;
		it.expected_hi = tag[127:64];
		it.expected_lo = tag[63:0];
		send_block(it);
	endtask

	task automatic send_middle(input logic [127:0] data);
		cmac_pkg::in_item_t it;
		it.data_hi = data[127:64];
		it.data_lo = data[63:0];
		it.valid_bytes = 5'($urandom_range(0, 31));
		it.last_block = 1'b0;
		it.expected_hi = rand64();
		it.expected_lo = rand64();
		send_block(it);
	endtask

	// One random message of one to four blocks, mostly short. Sometimes the
	// same message is sent again with the tag of the first copy as the
	// expected tag, possibly with one bit flipped, so that both outcomes of
	// the comparison show up.
	task automatic random_message();
		cmac_pkg::in_item_t blocks [$];
		cmac_pkg::in_item_t it;
		int nblk;
		int pick;
		logic [127:0] want;
		nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
		for (int b = 0; b < nblk; b++) begin
			it.data_hi = rand64();
			it.data_lo = rand64();
			it.last_block = (b == nblk - 1);
			pick = $urandom_range(0, 9);
			if (!it.last_block)
				it.valid_bytes = 5'($urandom_range(0, 31));
			else if (pick == 0)
				it.valid_bytes = 5'($urandom_range(17, 31));
			else if (pick < 4)
				it.valid_bytes = 5'd16;
			else
				it.valid_bytes = 5'($urandom_range(0, 15));
			it.expected_hi = rand64();
			it.expected_lo = rand64();
			blocks.push_back(it);
			send_block(it);
		end
		if ($urandom_range(0, 3) == 0) begin
			// Let the checker finish the accepting edge before its tag is read.
			@(negedge clk);
			in_valid <= 1'b0;
			want = last_tag;
			if ($urandom_range(0, 2) == 0)
				want[$urandom_range(0, 127)] ^= 1'b1;
			foreach (blocks[b]) begin
				it = blocks[b];
				if (it.last_block) begin
					it.expected_hi = want[127:64];
					it.expected_lo = want[63:0];
				end
				send_block(it);
			end
		end
	endtask

	initial begin
		logic [63:0] khi, klo;
		int sel;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = cmac_pkg::REG_KEY_HI;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		hold_go = 1'b0;
		items_sent = 0;
		keys_written = 0;
		burst_left = 4;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (40) @(posedge clk);

		// Directed part. First the reset key, which is all zeros.
		send_last({128{1'b1}}, 5'd16, '0);
		send_last('0, 5'd0, '0);

		// Published test vectors: empty and one-block messages with the right
		// tags, so the flag must come out clear.
		drain();
		set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
		send_last('0, 5'd0, 128'hbb1d6929e95937287fa37d129b756746);
		send_last(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16,
			128'h070a16b46b4d4144f79bdd9dd04a287c);
		// Chained messages ending in a full, a partial and an empty block.
		send_middle(128'h6bc1bee22e409f96e93d7e117393172a);
		send_last(128'hae2d8a571e03ac9c9eb76fac45af8e51, 5'd16, '0);
		send_middle({128{1'b1}});
		send_middle('0);
		send_last({128{1'b1}}, 5'd7, {128{1'b1}});
		send_middle({128{1'b1}});
		send_last({128{1'b1}}, 5'd0, '0);
		// Byte counts of one, fifteen, and above sixteen.
		send_last({128{1'b1}}, 5'd1, '0);
		send_last({128{1'b1}}, 5'd15, '0);
		send_last({128{1'b1}}, 5'd17, '0);
		send_last({128{1'b1}}, 5'd31, '0);

		// The all-ones key, then back to all zeros.
		drain();
		set_key({64{1'b1}}, {64{1'b1}});
		send_middle({128{1'b1}});
		send_last('0, 5'd16, {128{1'b1}});
		send_last({128{1'b1}}, 5'd8, '0);
		drain();
		set_key('0, '0);
		send_last(128'h0123456789abcdeffedcba9876543210, 5'd12, '0);
		drain();

		// Random part: ten phases, each of which loads a key.
		for (int phase = 0; phase < 10; phase++) begin
			sel = $urandom_range(0, 4);
			khi = (sel == 0) ? '0 : (sel == 1) ? {64{1'b1}} : rand64();
			klo = (sel == 0) ? {64{1'b1}} : (sel == 1) ? '0 : rand64();
			set_key(khi, klo);
			if (phase == 3) begin
				// Back the core up: the receiver holds off while the sender
				// keeps offering items without gaps.
				hold_go = 1'b1;
				burst_left = 1000;
			end
			while (items_sent < 40 + (phase + 1) * 100) begin
				random_message();
				// Once in a while the sender waits for every tag to come out.
				if ($urandom_range(0, 40) == 0)
					drain();
			end
			drain();
		end

		$display("covered %0d items, %0d key writes, %0d tags (%0d flagged mismatch)",
			items_sent, keys_written, tags_seen, mismatches_seen);
		$display("failures counted: %0d", errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### aes128_cmac_generate_verify_core.f
rtl/cmac_pkg.sv
rtl/cmac_front.sv
rtl/cmac_engine.sv
rtl/aes128_cmac_generate_verify_core.sv
sim/cmac_tag_checker.sv
sim/tb_aes128_cmac_generate_verify_core.sv
